/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside reset.
`define PTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle is followed by another in the next.
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTW_ASSERT(lbl, prop, msg)
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/ptw_pkg.sv */
// Types, constants and helper functions of the 16K-granule table walker.
`timescale 1ns / 1ps
package ptw_pkg;

    localparam int ADDR_W          = 48;
    localparam int DATA_W          = 64;
    localparam int IDX_W           = 11;
    localparam int ADDR_BITS_DEF   = 48;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int LVL1_SHIFT = 36;
    localparam int LVL2_SHIFT = 25;
    localparam int LVL3_SHIFT = 14;

    localparam logic [1:0] LVL1 = 2'd1;
    localparam logic [1:0] LVL2 = 2'd2;
    localparam logic [1:0] LVL3 = 2'd3;

    // Low descriptor bits that mark a block
    localparam logic [1:0] DESC_BLOCK = 2'b01;
    localparam logic [1:0] DESC_PAGE  = 2'b11;

    localparam logic [ADDR_W-1:0] OFF_L1 = 48'h000F_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] OFF_L2 = 48'h0000_01FF_FFFF;
    localparam logic [ADDR_W-1:0] OFF_L3 = 48'h0000_0000_3FFF;
    localparam logic [ADDR_W-1:0] PAGE_KEEP  = ~48'h0000_0000_0FFF;
    localparam logic [ADDR_W-1:0] TABLE_KEEP = ~48'h0000_0000_3FFF;

    typedef enum logic {
        MODE_REQUEST  = 1'b0,
        MODE_RESPONSE = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_BLOCK   = 2'd0,
        ST_INVALID = 2'd1,
        ST_TABLE   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // One classified request as it waits in the queue
    typedef struct packed {
        logic              is_resp;
        logic              stop_zero;
        logic [1:0]        stop;
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] word;      // level 1 entry address or descriptor bits
        logic [ADDR_W-1:0] root_m;
        logic [1:0]        desc_type;
    } ptw_item_t;

    // Walk state seen by the top level
    typedef struct packed {
        logic       busy;
        logic [1:0] level;
        logic [1:0] stop;
        logic       pop;
    } ptw_stat_t;

    function automatic logic [ADDR_W-1:0] addr_mask(input int bits);
        logic [DATA_W-1:0] m;
        m = (64'd1 << bits) - 64'd1;
        return (bits >= ADDR_W) ? {ADDR_W{1'b1}} : m[ADDR_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] level_index(input logic [ADDR_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL1:    idx = va[LVL1_SHIFT +: IDX_W];
            LVL2:    idx = va[LVL2_SHIFT +: IDX_W];
            default: idx = va[LVL3_SHIFT +: IDX_W];
        endcase
        return idx;
    endfunction

    // Descriptor address before masking: table + index * 8
    function automatic logic [ADDR_W-1:0] entry_sum(input logic [ADDR_W-1:0] tbl,
                                                    input logic [ADDR_W-1:0] va,
                                                    input logic [1:0] lvl);
        return tbl + ADDR_W'({level_index(va, lvl), 3'b000});
    endfunction

    function automatic logic [ADDR_W-1:0] offset_mask(input logic [1:0] lvl);
        logic [ADDR_W-1:0] m;
        unique case (lvl)
            LVL1:    m = OFF_L1;
            LVL2:    m = OFF_L2;
            default: m = OFF_L3;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/ptw_in_if.sv */
// Input channel of the walker: translate requests and descriptor responses.
`timescale 1ns / 1ps
interface ptw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [47:0] virt_addr;
    logic [47:0] root_table;
    logic [1:0]  stop_level;
    logic [63:0] read_data;

    modport source (output valid, mode, virt_addr, root_table, stop_level, read_data,
                    input ready);
    modport sink   (input valid, mode, virt_addr, root_table, stop_level, read_data,
                    output ready);
endinterface

/* hw/rtl/ptw_out_if.sv */
// Output channel of the walker: descriptor reads and walk answers.
`timescale 1ns / 1ps
interface ptw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [47:0] address;
    logic [1:0]  level;
    logic [47:0] entry_addr;
    logic [1:0]  status;

    modport source (output valid, kind, address, level, entry_addr, status,
                    input ready);
    modport sink   (input valid, kind, address, level, entry_addr, status,
                    output ready);
endinterface

/* hw/rtl/ptw_front.sv */
// Front end: accept requests and classify them into queue items.
`timescale 1ns / 1ps
module ptw_front
    import ptw_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    ptw_in_if.sink    walk_in,
    input  logic      q_ready,
    output logic      q_push,
    output ptw_item_t q_item
);

    localparam logic [ADDR_W-1:0] ADDR_MASK = addr_mask(ADDR_BITS);

    assign walk_in.ready = q_ready;
    assign q_push        = walk_in.valid && q_ready;

    always_comb
    begin
        q_item           = '0;
        q_item.is_resp   = (walk_in.mode == MODE_RESPONSE);
        q_item.stop_zero = (walk_in.stop_level == 2'd0);
        q_item.stop      = walk_in.stop_level;
        q_item.va        = walk_in.virt_addr;
        q_item.root_m    = walk_in.root_table & ADDR_MASK;
        q_item.desc_type = walk_in.read_data[1:0];
        // Level 1 entry address needs no walk state: work it out here
        if (walk_in.mode == MODE_RESPONSE)
        begin
            q_item.word = walk_in.read_data[ADDR_W-1:0];
        end
        else
        begin
            q_item.word = entry_sum(walk_in.root_table, walk_in.virt_addr, LVL1) & ADDR_MASK;
        end
    end

endmodule

/* hw/rtl/ptw_queue.sv */
// Small register queue between the front end and the walk engine.
`timescale 1ns / 1ps
module ptw_queue
    import ptw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ptw_item_t                  push_item,
    output logic                       not_full,
    input  logic                       pop,
    output logic                       not_empty,
    output ptw_item_t                  head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptw_item_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/ptw_back.sv */
// Walk engine: hold walk state, step it per item, register the answer.
`timescale 1ns / 1ps
module ptw_back
    import ptw_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  ptw_item_t  q_item,
    output logic       q_pop,
    ptw_out_if.source  walk_out,
    output ptw_stat_t  stat
);

    localparam logic [ADDR_W-1:0] ADDR_MASK  = addr_mask(ADDR_BITS);
    localparam logic [ADDR_W-1:0] PA_MASK    = ADDR_MASK & PAGE_KEEP;
    localparam logic [ADDR_W-1:0] TABLE_MASK = ADDR_MASK & TABLE_KEEP;

    logic              busy_reg,  busy_next;
    logic [ADDR_W-1:0] va_reg,    va_next;
    logic [1:0]        level_reg, level_next;
    logic [1:0]        stop_reg,  stop_next;
    logic [ADDR_W-1:0] ent_reg,   ent_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg,      kind_next;
    logic [ADDR_W-1:0] addr_reg,      addr_next;
    logic [1:0]        lvl_o_reg,     lvl_o_next;
    logic [ADDR_W-1:0] eaddr_reg,     eaddr_next;
    logic [1:0]        status_reg,    status_next;

    logic [1:0]        lvl_inc;
    logic [1:0]        block_code;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] next_tbl;
    logic [ADDR_W-1:0] next_ent;

    assign q_pop = q_valid && (!out_valid_reg || walk_out.ready);

    assign lvl_inc    = level_reg + 2'd1;
    assign block_code = (level_reg == LVL3) ? DESC_PAGE : DESC_BLOCK;
    assign off        = offset_mask(level_reg);
    assign next_tbl   = q_item.word & TABLE_MASK;
    assign next_ent   = entry_sum(next_tbl, va_reg, lvl_inc) & ADDR_MASK;

    always_comb
    begin
        busy_next   = busy_reg;
        va_next     = va_reg;
        level_next  = level_reg;
        stop_next   = stop_reg;
        ent_next    = ent_reg;

        out_valid_next = walk_out.ready ? 1'b0 : out_valid_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        lvl_o_next  = lvl_o_reg;
        eaddr_next  = eaddr_reg;
        status_next = status_reg;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            // Default answer: ignored, report the walk position
            kind_next   = KIND_DONE;
            addr_next   = '0;
            lvl_o_next  = level_reg;
            eaddr_next  = ent_reg;
            status_next = ST_IGNORED;
            priority if (!q_item.is_resp)
            begin
                priority if (busy_reg)
                begin
                    status_next = ST_IGNORED;
                end
                else if (q_item.stop_zero)
                begin
                    addr_next   = q_item.root_m;
                    lvl_o_next  = LVL1;
                    eaddr_next  = '0;
                    status_next = ST_TABLE;
                end
                else
                begin
                    busy_next   = 1'b1;
                    va_next     = q_item.va;
                    stop_next   = q_item.stop;
                    level_next  = LVL1;
                    ent_next    = q_item.word;
                    kind_next   = KIND_READ;
                    addr_next   = q_item.word;
                    lvl_o_next  = LVL1;
                    eaddr_next  = q_item.word;
                    status_next = ST_BLOCK;
                end
            end
            else if (!busy_reg)
            begin
                status_next = ST_IGNORED;
            end
            else if (!q_item.desc_type[0])
            begin
                busy_next   = 1'b0;
                status_next = ST_INVALID;
            end
            else if (q_item.desc_type == block_code)
            begin
                busy_next   = 1'b0;
                addr_next   = (q_item.word & PA_MASK & ~off) | (va_reg & off);
                status_next = ST_BLOCK;
            end
            else if ((level_reg >= stop_reg) || (level_reg == LVL3))
            begin
                busy_next   = 1'b0;
                addr_next   = next_tbl;
                status_next = ST_TABLE;
            end
            else
            begin
                level_next  = lvl_inc;
                ent_next    = next_ent;
                kind_next   = KIND_READ;
                addr_next   = next_ent;
                lvl_o_next  = lvl_inc;
                eaddr_next  = next_ent;
                status_next = ST_BLOCK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            va_reg        <= '0;
            level_reg     <= LVL1;
            stop_reg      <= LVL3;
            ent_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            va_reg        <= va_next;
            level_reg     <= level_next;
            stop_reg      <= stop_next;
            ent_reg       <= ent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        lvl_o_reg  <= lvl_o_next;
        eaddr_reg  <= eaddr_next;
        status_reg <= status_next;
    end

    assign walk_out.valid      = out_valid_reg;
    assign walk_out.kind       = kind_reg;
    assign walk_out.address    = addr_reg;
    assign walk_out.level      = lvl_o_reg;
    assign walk_out.entry_addr = eaddr_reg;
    assign walk_out.status     = status_reg;

    assign stat.busy  = busy_reg;
    assign stat.level = level_reg;
    assign stat.stop  = stop_reg;
    assign stat.pop   = q_pop;

endmodule

/* hw/rtl/page_table_walker_16k_top.sv */
// Top level of the 16K-granule translation table walker.
//
// Walks ARMv8 16K-granule tables from level 1. Every request on walk_in gets
// exactly one answer on walk_out, in order. A translate request (mode 0)
// answers with the read of its level 1 descriptor (kind 0), or at once with
// status "ended at table" when the stop level is zero. Each descriptor
// response (mode 1) answers with the next level's read, or ends the walk:
// block found (physical address = descriptor output bits OR the virtual
// offset), invalid entry, or ended at table (address of the next table)
// once the stop level or level 3 is reached. A translate request during a
// walk, or a response with no walk open, is answered with status "ignored"
// and leaves the walk untouched. Root tables are always physical; the
// kernel-virtual path is not built. Rate: one request per cycle while
// walk_out is ready. The front end classifies a request and computes its
// level 1 entry address in the cycle it is accepted, writing it into a
// QUEUE_DEPTH-entry queue; the walk engine takes one queue item per cycle
// while its output register is free or being taken, steps the walk state
// with one 48-bit add and registers the answer: a request passes the queue
// and its answer the output register. The queue and output register let
// either side stall independently. ADDR_BITS (40 to 52) sets the physical
// address width kept by the walker; addresses are reported in 48 bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module page_table_walker_16k_top
    import ptw_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ptw_in_if.sink     walk_in,
    ptw_out_if.source  walk_out
);

    // Queue handshake between front end and walk engine
    logic                             q_push;
    logic                             q_pop;
    logic                             q_not_full;
    logic                             q_not_empty;
    ptw_item_t                        q_in_item;
    ptw_item_t                        q_head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    ptw_stat_t                        back_stat;

    // Classify requests; stall the input only when the queue is full
    ptw_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .walk_in (walk_in),
        .q_ready (q_not_full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    ptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    // Step the walk and hold the answer until the sink takes it
    ptw_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .walk_out (walk_out),
        .stat     (back_stat)
    );

    // An open walk never goes deeper than its stop level
    `PTW_ASSERT(a_level_within_stop, back_stat.busy |-> (back_stat.level <= back_stat.stop), "walk level passed stop level")
    // A pending descriptor read always belongs to an open walk
    `PTW_ASSERT(a_read_has_walk, (walk_out.valid && (walk_out.kind == KIND_READ)) |-> back_stat.busy, "read request with no walk open")
    // Every item taken from the queue shows up as an answer next cycle
    `PTW_ASSERT_NEXT(a_pop_gives_answer, back_stat.pop, walk_out.valid, "queue item produced no answer")
    // The queue count stays within its depth
    `PTW_ASSERT(a_queue_bound, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue count exceeds depth")

endmodule
